[rtl/core/tlbpt_pkg.sv]
// Shared types and constants of the TLB page translator.
`default_nettype none

package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W  = 16;
  localparam int PAGE_W  = ADDR_W - OFFSET_BITS;
  localparam int FRAME_W = 8;
  localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FCNT_W  = 9;
  localparam int HCNT_W  = 32;

  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [FCNT_W-1:0]      fcnt_t;
  typedef logic [HCNT_W-1:0]      hcnt_t;

  // Registered TLB lookup result.
  typedef struct packed {
    logic   hit;
    frame_t frame;
  } lk_t;

  // TLB update request from the control logic.
  typedef struct packed {
    logic   touch;  // hit entry becomes most recent
    logic   fill;   // install page/frame in the victim entry
    page_t  page;
    frame_t frame;
  } upd_t;

endpackage

`default_nettype wire

[rtl/core/tlb_lru_page_translator_unit.sv]
// One transaction in flight: the block takes no new transaction until the last one completes.
// Accepting a transaction registers the TLB compare, the victim choice and the page-table read;
// completing it resolves hit / present / fault, registers the result, writes back the TLB and page table.
// Completion waits for a free output register; page-table read and write-back never coincide.
// Reset (async, active low) clears TLB valid bits and ranks, present bits, counters;
// no clearing pass, the block takes a transaction right after reset.
`default_nettype none

module tlb_lru_page_translator_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [15:0]              logical_address_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [15:0]                   phys_addr_o,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o,
  output logic                          out_of_frames_o,
  output logic [31:0]                   hits_so_far_o,
  output logic [8:0]                    faults_so_far_o
);
  import tlbpt_pkg::*;

  localparam fcnt_t FCNT_FULL = fcnt_t'(FRAME_COUNT);
  localparam hcnt_t HCNT_MAX  = '1;

  // control
  logic    busy_q;        // one transaction in flight
  logic    in_accept;
  logic    out_free;      // output register can take a new result
  logic    finish;        // in-flight transaction completes this cycle

  // in-flight transaction
  page_t   page_q;
  offset_t offset_q;

  // running counts
  hcnt_t   hit_count_q, hit_count_d;
  fcnt_t   fault_count_q, fault_count_d;

  // sub-block interfaces
  lk_t     lk;
  upd_t    upd;
  logic    pt_present;
  frame_t  pt_frame;
  logic    pt_wr;

  // resolution
  logic    is_fault;
  logic    is_oof;
  frame_t  frame;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign finish     = busy_q && out_free;

  tlbpt_tlb_array u_tlb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lk_en_i   (in_accept),
    .lk_page_i (logical_address_i[15:OFFSET_BITS]),
    .lk_o      (lk),
    .upd_i     (upd)
  );

  tlbpt_page_table u_pt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (in_accept),
    .rd_page_i    (logical_address_i[15:OFFSET_BITS]),
    .wr_en_i      (pt_wr),
    .wr_page_i    (page_q),
    .wr_frame_i   (frame),
    .rd_present_o (pt_present),
    .rd_frame_o   (pt_frame)
  );

  // Hit: TLB frame. Miss: page table frame, or allocate the next frame in order, or flag out of frames.
  always_comb begin
    is_fault      = 1'b0;
    is_oof        = 1'b0;
    frame         = lk.frame;
    hit_count_d   = hit_count_q;
    fault_count_d = fault_count_q;
    if (lk.hit) begin
      if (hit_count_q != HCNT_MAX) begin
        hit_count_d = hit_count_q + hcnt_t'(1);
      end
    end else if (pt_present) begin
      frame = pt_frame;
    end else if (fault_count_q < FCNT_FULL) begin
      is_fault      = 1'b1;
      frame         = fault_count_q[FRAME_W-1:0];
      fault_count_d = fault_count_q + fcnt_t'(1);
    end else begin
      is_oof = 1'b1;
    end
  end

  assign pt_wr = finish && is_fault;
  // touch, fill, page, frame
  assign upd   = {finish && lk.hit, finish && !lk.hit && !is_oof, page_q, frame};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      out_valid_o   <= 1'b0;
      hit_count_q   <= '0;
      fault_count_q <= '0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        out_valid_o   <= 1'b1;
        hit_count_q   <= hit_count_d;
        fault_count_q <= fault_count_d;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      page_q   <= logical_address_i[15:OFFSET_BITS];
      offset_q <= logical_address_i[OFFSET_BITS-1:0];
    end
    if (finish) begin
      phys_addr_o     <= is_oof ? '0 : {frame, offset_q};
      tlb_hit_o       <= lk.hit;
      page_fault_o    <= is_fault;
      out_of_frames_o <= is_oof;
      hits_so_far_o   <= hit_count_d;
      faults_so_far_o <= fault_count_d;
    end
  end

`ifndef SYNTH
  a_fault_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_count_q <= FCNT_FULL)
    else $error("fault count beyond frame count");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({tlb_hit_o, page_fault_o, out_of_frames_o}))
    else $error("result flags not exclusive");

  a_fault_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && is_fault) |=> (fault_count_q == $past(fault_count_q) + fcnt_t'(1)))
    else $error("fault did not advance frame allocation");

  a_oof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_frames_o) |->
      ((phys_addr_o == '0) && (faults_so_far_o == FCNT_FULL)))
    else $error("out-of-frames result inconsistent");

  a_pt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && pt_wr))
    else $error("page table read and write in same cycle");
`endif

endmodule

`default_nettype wire

[rtl/core/tlbpt_page_table.sv]
// Page table: frame memory with registered read, present bits in flops.
`default_nettype none

module tlbpt_page_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire tlbpt_pkg::page_t rd_page_i,
  input  wire logic             wr_en_i,
  input  wire tlbpt_pkg::page_t wr_page_i,
  input  wire tlbpt_pkg::frame_t wr_frame_i,
  output logic                  rd_present_o,
  output tlbpt_pkg::frame_t     rd_frame_o
);
  import tlbpt_pkg::*;

  frame_t          frame_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] present_q;

  // frame store, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      frame_mem[wr_page_i] <= wr_frame_i;
    end
    if (rd_en_i) begin
      rd_frame_o <= frame_mem[rd_page_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_o <= 1'b0;
    end else begin
      if (wr_en_i) begin
        present_q[wr_page_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_present_o <= present_q[rd_page_i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tlbpt_tlb_array.sv]
// Fully associative TLB with LRU ranks, registered lookup and victim select.
`default_nettype none

module tlbpt_tlb_array (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             lk_en_i,
  input  wire tlbpt_pkg::page_t lk_page_i,
  output tlbpt_pkg::lk_t        lk_o,
  input  wire tlbpt_pkg::upd_t  upd_i
);
  import tlbpt_pkg::*;

  localparam idx_t RANK_MAX = idx_t'(TLB_ENTRIES - 1);

  logic   valid_q [TLB_ENTRIES];
  idx_t   rank_q  [TLB_ENTRIES];
  page_t  page_q  [TLB_ENTRIES];
  frame_t frame_q [TLB_ENTRIES];

  logic hit_d;
  idx_t hit_idx_d;
  logic has_free;
  idx_t free_idx;
  idx_t lru_idx;
  idx_t hit_idx_q;
  idx_t victim_q;
  idx_t tgt;
  idx_t old_rank;
  logic   lk_hit_q;
  frame_t lk_frame_q;

  // Parallel compare; lowest index wins. Victim: lowest invalid, else rank 0.
  always_comb begin
    hit_d     = 1'b0;
    hit_idx_d = '0;
    has_free  = 1'b0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == lk_page_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_t'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = idx_t'(i);
      end
      if (valid_q[i] && (rank_q[i] == '0)) begin
        lru_idx = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_hit_q  <= 1'b0;
      hit_idx_q <= '0;
      victim_q  <= '0;
    end else if (lk_en_i) begin
      lk_hit_q  <= hit_d;
      hit_idx_q <= hit_idx_d;
      victim_q  <= has_free ? free_idx : lru_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_en_i) begin
      lk_frame_q <= frame_q[hit_idx_d];
    end
  end

  assign lk_o = {lk_hit_q, lk_frame_q};

  // fill target always leaves rank 0 behind (invalid or LRU entry)
  assign tgt      = upd_i.fill ? victim_q : hit_idx_q;
  assign old_rank = upd_i.fill ? '0 : rank_q[hit_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        valid_q[j] <= 1'b0;
        rank_q[j]  <= '0;
      end
    end else if (upd_i.touch || upd_i.fill) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (idx_t'(j) == tgt) begin
          rank_q[j] <= RANK_MAX;
          if (upd_i.fill) begin
            valid_q[j] <= 1'b1;
          end
        end else if (valid_q[j] && (rank_q[j] > old_rank)) begin
          rank_q[j] <= rank_q[j] - idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.fill) begin
      page_q[victim_q]  <= upd_i.page;
      frame_q[victim_q] <= upd_i.frame;
    end
  end

endmodule

`default_nettype wire

[verif/tlb_lru_page_translator_unit_tb.sv]
// Self-checking testbench for the TLB page translator: address streams, LRU and fault checks.

module tlb_lru_page_translator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbpt_pkg::*;

  // Receiver hold-off length used to back the pipeline up into the input.
  localparam int HOLD_CYCLES = 150;
  // Random items per idle phase, and how often the working set is redrawn.
  localparam int PHASE_ITEMS = 200;
  localparam int WSET_SPAN   = 40;

  // One translation result as seen on the output channel.
  typedef struct {
    logic [15:0] phys;
    logic        hit;
    logic        fault;
    logic        oof;
    hcnt_t       hits;
    fcnt_t       faults;
  } xlat_t;

  // Shadow TLB + page table; predicts each translation and checks results in order.
  class xlat_scoreboard;
    bit     tlb_vld[TLB_ENTRIES];
    page_t  tlb_pg[TLB_ENTRIES];
    frame_t tlb_frm[TLB_ENTRIES];
    idx_t   tlb_rank[TLB_ENTRIES];
    bit     pg_present[PAGE_COUNT];
    frame_t pg_frame[PAGE_COUNT];
    fcnt_t  fault_cnt;
    hcnt_t  hit_cnt;
    xlat_t  expected_xlats[$];
    int     errors;
    int     checked;
    int     hits_seen;
    int     faults_seen;

    function new();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_vld[i]  = 1'b0;
        tlb_rank[i] = '0;
      end
      for (int i = 0; i < PAGE_COUNT; i++) pg_present[i] = 1'b0;
      fault_cnt   = '0;
      hit_cnt     = '0;
      errors      = 0;
      checked     = 0;
      hits_seen   = 0;
      faults_seen = 0;
    endfunction

    // Entry idx becomes most recent; younger valid entries each age by one.
    function void make_recent(int idx);
      idx_t old;
      old = tlb_rank[idx];
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (j != idx && tlb_vld[j] && tlb_rank[j] > old) tlb_rank[j] = tlb_rank[j] - 1'b1;
      end
      tlb_rank[idx] = idx_t'(TLB_ENTRIES - 1);
    endfunction

    // Lowest invalid entry, else lowest index holding the smallest rank.
    function int pick_victim();
      int best;
      best = 0;
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        if (!tlb_vld[j]) return j;
      end
      for (int j = 1; j < TLB_ENTRIES; j++) begin
        if (tlb_rank[j] < tlb_rank[best]) best = j;
      end
      return best;
    endfunction

    function xlat_t translate(logic [15:0] addr);
      xlat_t   r;
      page_t   pg;
      offset_t off;
      frame_t  frm;
      bit      hit;
      bit      flt;
      bit      oof;
      int      v;
      pg  = addr[15:8];
      off = addr[7:0];
      frm = '0;
      hit = 1'b0;
      flt = 1'b0;
      oof = 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (!hit && tlb_vld[i] && tlb_pg[i] == pg) begin
          hit = 1'b1;
          frm = tlb_frm[i];
          make_recent(i);
          if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
        end
      end
      if (!hit) begin
        if (pg_present[pg]) begin
          frm = pg_frame[pg];
        end else if (fault_cnt < FRAME_COUNT) begin
          frm            = fault_cnt[FRAME_W-1:0];
          fault_cnt      = fault_cnt + 1'b1;
          pg_present[pg] = 1'b1;
          pg_frame[pg]   = frm;
          flt            = 1'b1;
        end else begin
          oof = 1'b1;
        end
        if (!oof) begin
          v = pick_victim();
          tlb_pg[v]  = pg;
          tlb_frm[v] = frm;
          if (!tlb_vld[v]) tlb_rank[v] = '0;
          tlb_vld[v] = 1'b1;
          make_recent(v);
        end
      end
      r.phys   = oof ? 16'h0000 : {frm, off};
      r.hit    = hit;
      r.fault  = flt;
      r.oof    = oof;
      r.hits   = hit_cnt;
      r.faults = fault_cnt;
      return r;
    endfunction

    function void note_address(logic [15:0] addr);
      expected_xlats.push_back(translate(addr));
    endfunction

    function int pending();
      return expected_xlats.size();
    endfunction

    function void check_translation(xlat_t got);
      xlat_t exp_r;
      if (expected_xlats.size() == 0) begin
        $error("unexpected result transaction: phys_addr %h", got.phys);
        errors++;
        return;
      end
      exp_r = expected_xlats.pop_front();
      checked++;
      if (exp_r.hit) hits_seen++;
      if (exp_r.fault) faults_seen++;
      if (got.phys !== exp_r.phys) begin
        $error("phys_addr: expected %h, actual %h", exp_r.phys, got.phys);
        errors++;
      end
      if (got.hit !== exp_r.hit) begin
        $error("tlb_hit: expected %b, actual %b", exp_r.hit, got.hit);
        errors++;
      end
      if (got.fault !== exp_r.fault) begin
        $error("page_fault: expected %b, actual %b", exp_r.fault, got.fault);
        errors++;
      end
      if (got.oof !== exp_r.oof) begin
        $error("out_of_frames: expected %b, actual %b", exp_r.oof, got.oof);
        errors++;
      end
      if (got.hits !== exp_r.hits) begin
        $error("hits_so_far: expected %0d, actual %0d", exp_r.hits, got.hits);
        errors++;
      end
      if (got.faults !== exp_r.faults) begin
        $error("faults_so_far: expected %0d, actual %0d", exp_r.faults, got.faults);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [15:0] logical_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [15:0] phys_addr_o;
  logic        tlb_hit_o;
  logic        page_fault_o;
  logic        out_of_frames_o;
  logic [31:0] hits_so_far_o;
  logic [8:0]  faults_so_far_o;

  tlb_lru_page_translator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .phys_addr_o        (phys_addr_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .out_of_frames_o    (out_of_frames_o),
    .hits_so_far_o      (hits_so_far_o),
    .faults_so_far_o    (faults_so_far_o)
  );

  always #1 clk_i = ~clk_i;

  xlat_scoreboard sb = new();

  // Idle knobs, changed only between phases while the pipe is drained.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Hold-off request: main bumps hold_reqs, the receiver counts the stretch out.
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Working set for locality-heavy address streams.
  page_t work_set[20];
  int    work_size = 4;
  page_t last_page = '0;

  // ---------------------------------------------------------------------------
  // Result side: check on each accepted transaction, then pick next stall.
  // Signals read right after the edge hold their pre-edge values, so the
  // accept condition here matches what the DUT saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    xlat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.phys   = phys_addr_o;
      got.hit    = tlb_hit_o;
      got.fault  = page_fault_o;
      got.oof    = out_of_frames_o;
      got.hits   = hits_so_far_o;
      got.faults = faults_so_far_o;
      sb.check_translation(got);
    end
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called right after a rising edge; returns at the edge that
  // accepted the transaction. Payload holds steady while stalled.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    logical_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_address(addr);
  endtask

  // Sender goes quiet until every predicted result has been checked.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // New working set; sizes above the TLB depth force LRU thrashing.
  task automatic refresh_work_set();
    work_size = $urandom_range(20, 3);
    for (int i = 0; i < 20; i++) work_set[i] = page_t'($urandom_range(255));
  endtask

  // Mostly working-set hits, some neighbor pages, a little uniform noise.
  task automatic next_address(output logic [15:0] addr);
    int    sel;
    page_t pg;
    sel = $urandom_range(99);
    if (sel < 75) pg = work_set[$urandom_range(work_size - 1)];
    else if (sel < 90) pg = last_page + page_t'($urandom_range(3));
    else pg = page_t'($urandom_range(255));
    last_page = pg;
    addr = {pg, offset_t'($urandom_range(255))};
  endtask

  // Every page once, in shuffled order: drives the fault count to its top.
  task automatic page_sweep();
    page_t order[PAGE_COUNT];
    page_t tmp;
    int    k;
    for (int i = 0; i < PAGE_COUNT; i++) order[i] = page_t'(i);
    for (int i = PAGE_COUNT - 1; i > 0; i--) begin
      k        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < PAGE_COUNT; i++) send_item({order[i], offset_t'($urandom_range(255))});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] addr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme addresses, first faults, hits on the same page with a
    // different offset, filling every TLB entry, then an eviction of the LRU
    // entry and a refill of an evicted page from the page table (no fault).
    send_item(16'h0000);
    send_item(16'hFFFF);
    send_item(16'h00FF);
    send_item(16'hFF00);
    send_item(16'hAA55);
    send_item(16'h55AA);
    for (int p = 1; p <= 12; p++) send_item({page_t'(p), offset_t'($urandom_range(255))});
    send_item(16'h0042);  // hit: page 0 becomes most recent
    send_item(16'h80C3);  // fault with a full TLB: evicts page FF (least recent)
    send_item(16'hFF7E);  // miss, page table hit: refill without a fault
    in_valid_i <= 1'b0;
    drain();

    // Random phases cycle through the idle patterns. Each phase ends with
    // the sender paused until all outstanding results have been checked.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      // Long receiver hold-off while the sender keeps pushing: the pipe
      // fills and in_stall_o must back up.
      if (ph == 0 || ph == 4) hold_reqs <= hold_reqs + 1;
      if (ph == 5) page_sweep();
      refresh_work_set();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % WSET_SPAN == WSET_SPAN - 1) refresh_work_set();
        next_address(addr);
        send_item(addr);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    // Let the pipe settle before the verdict.
    repeat (4) @(posedge clk_i);
    $display("Summary: %0d translations checked, %0d TLB hits, %0d page faults",
             sb.checked, sb.hits_seen, sb.faults_seen);
    $display("Covered directed LRU eviction, full page sweep, four idle patterns, hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
